// ----- sv/oltab_pkg.sv -----
// oltab_pkg: shared types for the ordered list table engine
// beat payloads, opcodes, status codes, controller/datapath command and status structs
// no dependencies
package oltab_pkg;

    typedef enum logic [2:0] {
        OP_APPEND      = 3'd0,
        OP_INSERT_AT   = 3'd1,
        OP_DELETE_AT   = 3'd2,
        OP_DELETE_KEY  = 3'd3,
        OP_LINEAR_FIND = 3'd4,
        OP_BINARY_FIND = 3'd5,
        OP_SORT        = 3'd6,
        OP_READ_AT     = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [5:0]         position;
        logic signed [31:0] key_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [4:0]         found_index;
        logic signed [31:0] read_value;
        logic [5:0]         fill_count;
    } out_item_t;

    // read address select
    typedef enum logic [2:0] {
        RD_ZERO, RD_CNTM1, RD_POS, RD_POSM1, RD_PTRP1, RD_PTRP2, RD_PTRM2, RD_MID
    } rd_sel_t;

    // write address select
    typedef enum logic [2:0] {
        WA_COUNT, WA_PTR, WA_PTRM1, WA_POSM1, WA_END
    } wa_sel_t;

    typedef enum logic [1:0] {
        WD_KEY, WD_RDATA, WD_CARRY, WD_SORT
    } wd_sel_t;

    typedef enum logic [2:0] {
        P_HOLD, P_ZERO, P_INC, P_DEC, P_CNT, P_POSM1, P_MID
    } ptr_op_t;

    typedef enum logic [1:0] {
        C_HOLD, C_INC, C_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        CA_HOLD, CA_LOAD, CA_SORT
    } carry_op_t;

    typedef enum logic [1:0] {
        E_HOLD, E_INIT, E_DEC
    } end_op_t;

    typedef enum logic [1:0] {
        B_HOLD, B_INIT, B_HI, B_LO
    } bs_op_t;

    typedef enum logic [1:0] {
        IX_COUNT, IX_POSM1, IX_PTR
    } ix_sel_t;

    typedef struct packed {
        logic      capture;
        logic      rd_en;
        rd_sel_t   rd_sel;
        logic      wr_en;
        wa_sel_t   wa_sel;
        wd_sel_t   wd_sel;
        ptr_op_t   ptr_op;
        cnt_op_t   cnt_op;
        carry_op_t carry_op;
        end_op_t   end_op;
        bs_op_t    bs_op;
        logic      res_status_we;
        status_t   res_status;
        logic      res_idx_we;
        ix_sel_t   ix_sel;
        logic      res_val_we;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic cnt_le1;
        logic ins_direct;
        logic ins_bad;
        logic pos_bad;
        logic pos_last;
        logic match;
        logic ptr_last;
        logic shup_done;
        logic shdn_done;
        logic bs_open;
        logic bs_gt;
        logic sort_at_end;
        logic sort_last_pass;
        logic out_free;
    } stat_t;

endpackage

// ----- sv/oltab_ctrl.sv -----
// oltab_ctrl: sequencing state machine for the ordered list table engine
// drives oltab_pkg::cmd_t to the datapath, reads oltab_pkg::stat_t back
// depends on oltab_pkg
module oltab_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  oltab_pkg::stat_t  st,
    output oltab_pkg::cmd_t   cmd
);
    import oltab_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_DECODE    = 13'b0000000000010,
        S_SCAN      = 13'b0000000000100,
        S_SHIFTUP   = 13'b0000000001000,
        S_PUT       = 13'b0000000010000,
        S_SHIFTDN   = 13'b0000000100000,
        S_READ_OUT  = 13'b0000001000000,
        S_BS_RD     = 13'b0000010000000,
        S_BS_CMP    = 13'b0000100000000,
        S_SORT_LOAD = 13'b0001000000000,
        S_SORT_STEP = 13'b0010000000000,
        S_SORT_END  = 13'b0100000000000,
        S_DONE      = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                unique case (st.op)
                    OP_APPEND, OP_INSERT_AT:
                    begin
                        if (st.full)
                        begin
                            cmd.res_status_we = 1'b1;
                            cmd.res_status    = ST_FULL;
                        end
                        else if (st.op == OP_APPEND || st.ins_direct)
                        begin
                            cmd.wr_en      = 1'b1;
                            cmd.wa_sel     = WA_COUNT;
                            cmd.wd_sel     = WD_KEY;
                            cmd.res_idx_we = 1'b1;
                            cmd.ix_sel     = IX_COUNT;
                            cmd.cnt_op     = C_INC;
                        end
                        else if (st.ins_bad)
                        begin
                            cmd.res_status_we = 1'b1;
                            cmd.res_status    = ST_BADPOS;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_CNTM1;
                            cmd.ptr_op = P_CNT;
                            state_next = S_SHIFTUP;
                        end
                    end
                    OP_DELETE_AT:
                    begin
                        if (st.empty)
                        begin
                            cmd.res_status_we = 1'b1;
                            cmd.res_status    = ST_EMPTY;
                        end
                        else if (st.pos_bad)
                        begin
                            cmd.res_status_we = 1'b1;
                            cmd.res_status    = ST_BADPOS;
                        end
                        else
                        begin
                            cmd.res_idx_we = 1'b1;
                            cmd.ix_sel     = IX_POSM1;
                            cmd.ptr_op     = P_POSM1;
                            if (st.pos_last)
                            begin
                                cmd.cnt_op = C_DEC;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = RD_POS;
                                state_next = S_SHIFTDN;
                            end
                        end
                    end
                    OP_DELETE_KEY, OP_LINEAR_FIND:
                    begin
                        if (st.empty)
                        begin
                            cmd.res_status_we = 1'b1;
                            cmd.res_status    = (st.op == OP_DELETE_KEY) ? ST_EMPTY
                                                                         : ST_NOTFOUND;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_ZERO;
                            cmd.ptr_op = P_ZERO;
                            state_next = S_SCAN;
                        end
                    end
                    OP_BINARY_FIND:
                    begin
                        cmd.bs_op  = B_INIT;
                        state_next = S_BS_RD;
                    end
                    OP_SORT:
                    begin
                        if (!st.cnt_le1)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_ZERO;
                            cmd.ptr_op = P_ZERO;
                            cmd.end_op = E_INIT;
                            state_next = S_SORT_LOAD;
                        end
                    end
                    OP_READ_AT:
                    begin
                        if (st.empty)
                        begin
                            cmd.res_status_we = 1'b1;
                            cmd.res_status    = ST_EMPTY;
                        end
                        else if (st.pos_bad)
                        begin
                            cmd.res_status_we = 1'b1;
                            cmd.res_status    = ST_BADPOS;
                        end
                        else
                        begin
                            cmd.rd_en      = 1'b1;
                            cmd.rd_sel     = RD_POSM1;
                            cmd.res_idx_we = 1'b1;
                            cmd.ix_sel     = IX_POSM1;
                            state_next     = S_READ_OUT;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                if (st.match)
                begin
                    cmd.res_idx_we = 1'b1;
                    cmd.ix_sel     = IX_PTR;
                    state_next     = S_DONE;
                    if (st.op == OP_DELETE_KEY)
                    begin
                        if (st.ptr_last)
                        begin
                            cmd.cnt_op = C_DEC;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_PTRP1;
                            state_next = S_SHIFTDN;
                        end
                    end
                end
                else if (st.ptr_last)
                begin
                    cmd.res_status_we = 1'b1;
                    cmd.res_status    = ST_NOTFOUND;
                    state_next        = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTRP1;
                    cmd.ptr_op = P_INC;
                end
            end
            S_SHIFTDN:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_PTR;
                cmd.wd_sel = WD_RDATA;
                if (st.shdn_done)
                begin
                    cmd.cnt_op = C_DEC;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTRP2;
                    cmd.ptr_op = P_INC;
                end
            end
            S_SHIFTUP:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_PTR;
                cmd.wd_sel = WD_RDATA;
                if (st.shup_done)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTRM2;
                    cmd.ptr_op = P_DEC;
                end
            end
            S_PUT:
            begin
                cmd.wr_en      = 1'b1;
                cmd.wa_sel     = WA_POSM1;
                cmd.wd_sel     = WD_KEY;
                cmd.res_idx_we = 1'b1;
                cmd.ix_sel     = IX_POSM1;
                cmd.cnt_op     = C_INC;
                state_next     = S_DONE;
            end
            S_READ_OUT:
            begin
                cmd.res_val_we = 1'b1;
                state_next     = S_DONE;
            end
            S_BS_RD:
            begin
                if (st.bs_open)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_MID;
                    cmd.ptr_op = P_MID;
                    state_next = S_BS_CMP;
                end
                else
                begin
                    cmd.res_status_we = 1'b1;
                    cmd.res_status    = ST_NOTFOUND;
                    state_next        = S_DONE;
                end
            end
            S_BS_CMP:
            begin
                if (st.match)
                begin
                    cmd.res_idx_we = 1'b1;
                    cmd.ix_sel     = IX_PTR;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.bs_op  = st.bs_gt ? B_HI : B_LO;
                    state_next = S_BS_RD;
                end
            end
            S_SORT_LOAD:
            begin
                cmd.carry_op = CA_LOAD;
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = RD_PTRP1;
                cmd.ptr_op   = P_INC;
                state_next   = S_SORT_STEP;
            end
            S_SORT_STEP:
            begin
                // smaller of the pair drops to the slot below, larger rides on
                cmd.wr_en    = 1'b1;
                cmd.wa_sel   = WA_PTRM1;
                cmd.wd_sel   = WD_SORT;
                cmd.carry_op = CA_SORT;
                if (st.sort_at_end)
                begin
                    state_next = S_SORT_END;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTRP1;
                    cmd.ptr_op = P_INC;
                end
            end
            S_SORT_END:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_END;
                cmd.wd_sel = WD_CARRY;
                if (st.sort_last_pass)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.end_op = E_DEC;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_ZERO;
                    cmd.ptr_op = P_ZERO;
                    state_next = S_SORT_LOAD;
                end
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/oltab_dp.sv -----
// oltab_dp: datapath of the ordered list table engine
// list memory, fill count, pointers, compares and the output beat register
// depends on oltab_pkg
module oltab_dp #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  oltab_pkg::in_item_t  in_data,
    input  oltab_pkg::cmd_t      cmd,
    output oltab_pkg::stat_t     st,
    output logic                 out_valid,
    input  logic                 out_ready,
    output oltab_pkg::out_item_t out_data
);
    import oltab_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int XW = ((CW > 6) ? CW : 6) + 1;

    logic signed [31:0] list_mem [LIST_DEPTH];
    logic signed [31:0] rdata_reg;

    logic [2:0]         op_reg, op_next;
    logic [5:0]         pos_reg, pos_next;
    logic signed [31:0] key_reg, key_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic [CW-1:0]      end_reg, end_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic signed [31:0] carry_reg, carry_next;
    status_t            res_status_reg, res_status_next;
    logic [4:0]         res_idx_reg, res_idx_next;
    logic signed [31:0] res_val_reg, res_val_next;
    out_item_t          out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic [XW-1:0]      pos_x, cnt_x, ptr_x, end_x;
    logic [XW-1:0]      rd_full, wr_full, ix_full;
    logic [CW:0]        bs_sum;
    logic [CW-1:0]      mid;
    logic               sort_less;
    logic signed [31:0] wr_data;

    assign pos_x  = XW'(pos_reg);
    assign cnt_x  = XW'(count_reg);
    assign ptr_x  = XW'(ptr_reg);
    assign end_x  = XW'(end_reg);
    assign bs_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid    = bs_sum[CW:1];
    assign sort_less = rdata_reg < carry_reg;

    always_comb
    begin
        st.op             = op_t'(op_reg);
        st.full           = count_reg == CW'(LIST_DEPTH);
        st.empty          = count_reg == '0;
        st.cnt_le1        = cnt_x <= XW'(1);
        st.ins_direct     = (count_reg == '0) || (pos_x == cnt_x + XW'(1));
        st.ins_bad        = (pos_x == '0) || (pos_x > cnt_x + XW'(1));
        st.pos_bad        = (pos_x == '0) || (pos_x > cnt_x);
        st.pos_last       = pos_x == cnt_x;
        st.match          = rdata_reg == key_reg;
        st.ptr_last       = ptr_x + XW'(1) == cnt_x;
        st.shup_done      = ptr_x == pos_x;
        st.shdn_done      = ptr_x + XW'(2) == cnt_x;
        st.bs_open        = lo_reg < hi_reg;
        st.bs_gt          = rdata_reg > key_reg;
        st.sort_at_end    = ptr_reg == end_reg;
        st.sort_last_pass = end_reg == CW'(1);
        st.out_free       = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_ZERO:  rd_full = '0;
            RD_CNTM1: rd_full = cnt_x - XW'(1);
            RD_POS:   rd_full = pos_x;
            RD_POSM1: rd_full = pos_x - XW'(1);
            RD_PTRP1: rd_full = ptr_x + XW'(1);
            RD_PTRP2: rd_full = ptr_x + XW'(2);
            RD_PTRM2: rd_full = ptr_x - XW'(2);
            RD_MID:   rd_full = XW'(mid);
            default:  rd_full = '0;
        endcase

        unique case (cmd.wa_sel)
            WA_COUNT: wr_full = cnt_x;
            WA_PTR:   wr_full = ptr_x;
            WA_PTRM1: wr_full = ptr_x - XW'(1);
            WA_POSM1: wr_full = pos_x - XW'(1);
            WA_END:   wr_full = end_x;
            default:  wr_full = '0;
        endcase

        unique case (cmd.wd_sel)
            WD_KEY:   wr_data = key_reg;
            WD_RDATA: wr_data = rdata_reg;
            WD_CARRY: wr_data = carry_reg;
            WD_SORT:  wr_data = sort_less ? rdata_reg : carry_reg;
            default:  wr_data = key_reg;
        endcase

        unique case (cmd.ix_sel)
            IX_COUNT: ix_full = cnt_x;
            IX_POSM1: ix_full = pos_x - XW'(1);
            IX_PTR:   ix_full = ptr_x;
            default:  ix_full = '0;
        endcase
    end

    // list storage, registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            list_mem[wr_full[AW-1:0]] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= list_mem[rd_full[AW-1:0]];
        end
    end

    always_comb
    begin
        op_next         = op_reg;
        pos_next        = pos_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_val_next    = res_val_reg;
        if (cmd.capture)
        begin
            op_next         = in_data.opcode;
            pos_next        = in_data.position;
            key_next        = in_data.key_value;
            res_status_next = ST_OK;
            res_idx_next    = '0;
            res_val_next    = '0;
        end
        if (cmd.res_status_we)
        begin
            res_status_next = cmd.res_status;
        end
        if (cmd.res_idx_we)
        begin
            res_idx_next = ix_full[4:0];
        end
        if (cmd.res_val_we)
        begin
            res_val_next = rdata_reg;
        end

        unique case (cmd.cnt_op)
            C_HOLD:  count_next = count_reg;
            C_INC:   count_next = count_reg + CW'(1);
            C_DEC:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase

        unique case (cmd.ptr_op)
            P_HOLD:  ptr_next = ptr_reg;
            P_ZERO:  ptr_next = '0;
            P_INC:   ptr_next = ptr_reg + CW'(1);
            P_DEC:   ptr_next = ptr_reg - CW'(1);
            P_CNT:   ptr_next = count_reg;
            P_POSM1: ptr_next = CW'(pos_x - XW'(1));
            P_MID:   ptr_next = mid;
            default: ptr_next = ptr_reg;
        endcase

        unique case (cmd.end_op)
            E_HOLD:  end_next = end_reg;
            E_INIT:  end_next = count_reg - CW'(1);
            E_DEC:   end_next = end_reg - CW'(1);
            default: end_next = end_reg;
        endcase

        lo_next = lo_reg;
        hi_next = hi_reg;
        unique case (cmd.bs_op)
            B_HOLD:
            begin
            end
            B_INIT:
            begin
                lo_next = '0;
                hi_next = count_reg;
            end
            B_HI:
            begin
                hi_next = ptr_reg;
            end
            B_LO:
            begin
                lo_next = ptr_reg + CW'(1);
            end
            default:
            begin
            end
        endcase

        unique case (cmd.carry_op)
            CA_HOLD: carry_next = carry_reg;
            CA_LOAD: carry_next = rdata_reg;
            CA_SORT: carry_next = sort_less ? carry_reg : rdata_reg;
            default: carry_next = carry_reg;
        endcase

        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.out_load)
        begin
            out_next.status      = res_status_reg;
            out_next.found_index = res_idx_reg;
            out_next.read_value  = res_val_reg;
            out_next.fill_count  = 6'(count_reg);
            out_valid_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        key_reg        <= key_next;
        ptr_reg        <= ptr_next;
        end_reg        <= end_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        carry_reg      <= carry_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_val_reg    <= res_val_next;
        out_reg        <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- sv/ordered_list_table_engine.sv -----
// Ordered list table engine: a bounded list of signed 32-bit keys held in a
// memory with one read and one write port and a registered read, worked on
// one beat at a time. Insert at a position moves the entries from that
// position on up by one and delete at a position moves the entries after it
// down by one; delete by key and linear find scan from the start, delete by
// key then moving the entries after the match down; binary find halves the
// search range each step; sort is a bubble sort of n-1 passes, n being the
// fill count. The memory takes one read and one write per cycle.
// Results sit in an output register, so a new beat is taken while the last
// result still waits. The list contents come out of reset undefined and the
// fill count comes out as zero.
// depends on oltab_pkg, oltab_ctrl, oltab_dp
module ordered_list_table_engine #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  oltab_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output oltab_pkg::out_item_t out_data
);
    import oltab_pkg::*;

    cmd_t  cmd;
    stat_t st;

    oltab_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    oltab_dp #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
